// ===== hw/rtl/xmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmr_pkg
// Shared constants, types and the CRC byte update of the XMODEM receiver.
// ----------------------------------------------------------------------------
package xmr_pkg;

  localparam int MAX_BLOCK_DEF = 1024;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TMO   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEAD   = 3'd1;
  localparam logic [2:0] PH_BLOCK  = 3'd2;
  localparam logic [2:0] PH_CAN    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_CANCEL = 3'd5;
  localparam logic [2:0] PH_ABORT  = 3'd6;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_CANCEL = 3'd3;
  localparam logic [2:0] ST_ABORT  = 3'd4;

  localparam logic [1:0] REG_USE_CRC = 2'd0;
  localparam logic [1:0] REG_BYTES   = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;
  localparam logic [1:0] REG_RETRY   = 2'd3;

  // One result item as it leaves the block.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        commit_valid;
    logic [31:0] commit_address;
    logic [10:0] commit_length;
    logic [2:0]  status;
    logic [31:0] total_received;
    logic [7:0]  read_data;
    logic        last;
  } res_t;

  // Up to three results of one item, handed from the engine to the queue.
  typedef struct packed {
    logic [1:0]  count;      // number of results minus one
    logic [7:0]  tx_byte;    // shared by all results
    logic        tx_valid;
    logic        commit_valid;
    logic [31:0] commit_address;
    logic [10:0] commit_length;
    logic [2:0]  status;
    logic [31:0] total_received;
    logic        is_read;
  } burst_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/xmr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmr_regs
// APB configuration registers of the XMODEM receiver.
// ----------------------------------------------------------------------------
module xmr_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        use_crc,
  output logic [31:0] bytes_to_receive,
  output logic [31:0] start_address,
  output logic [7:0]  retry_limit
);

  logic        use_crc_r;
  logic [31:0] bytes_r, start_r;
  logic [7:0]  retry_r;
  logic [1:0]  idx;

  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_crc_r <= 1'b1;
      bytes_r   <= '0;
      start_r   <= '0;
      retry_r   <= 8'd32;
    end else if (psel && penable && pwrite) begin
      case (idx)
        xmr_pkg::REG_USE_CRC: use_crc_r <= pwdata[0];
        xmr_pkg::REG_BYTES:   bytes_r   <= pwdata;
        xmr_pkg::REG_START:   start_r   <= pwdata;
        xmr_pkg::REG_RETRY:   retry_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      xmr_pkg::REG_USE_CRC: prdata = {31'd0, use_crc_r};
      xmr_pkg::REG_BYTES:   prdata = bytes_r;
      xmr_pkg::REG_START:   prdata = start_r;
      xmr_pkg::REG_RETRY:   prdata = {24'd0, retry_r};
      default:              prdata = '0;
    endcase
  end

  assign use_crc          = use_crc_r;
  assign bytes_to_receive = bytes_r;
  assign start_address    = start_r;
  assign retry_limit      = retry_r;

endmodule

// ===== hw/rtl/xmr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmr_engine
// Protocol state and payload buffer; one item per cycle, taken when in_go is set, into a burst.
// ----------------------------------------------------------------------------
module xmr_engine #(
  parameter int MAX_BLOCK = xmr_pkg::MAX_BLOCK_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_go,
  input  logic [1:0]           op,
  input  logic [7:0]           rx_byte,
  input  logic [9:0]           read_index,
  input  logic                 use_crc,
  input  logic [31:0]          bytes_to_receive,
  input  logic [31:0]          start_address,
  input  logic [7:0]           retry_limit,
  output logic                 burst_valid,
  output xmr_pkg::burst_t      burst,
  output logic [7:0]           read_data
);

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  logic [7:0] mem [MAX_BLOCK];
  logic [7:0] rd_q;
  logic       rd_zero_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic        recv_r, recv_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic        long_r, long_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [7:0]  bnum_r, bnum_nxt, bcmp_r, bcmp_nxt;
  logic [15:0] crc_r, crc_nxt, trl_r, trl_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] addr_r, addr_nxt, cnt_r, cnt_nxt;

  logic            bv_r;
  xmr_pkg::burst_t b_r, b_nxt;

  logic        wr_en;
  logic [10:0] k;
  logic [10:0] size, total;
  logic [31:0] remain;
  logic [10:0] len;
  logic [15:0] trl_new;
  logic        ok, is_new, is_old;
  logic [7:0]  rt_inc;
  logic [7:0]  sbyte;

  assign sbyte = use_crc ? xmr_pkg::B_C : xmr_pkg::B_NAK;
  assign k     = pos_r - 11'd2;
  assign size  = long_r ? 11'd1024 : 11'd128;
  assign total = size + (use_crc ? 11'd4 : 11'd3);
  assign remain = bytes_to_receive - cnt_r;
  assign trl_new = {trl_r[7:0], rx_byte};
  assign rt_inc = retry_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r; retry_nxt = retry_r; recv_nxt = recv_r; exp_nxt = exp_r;
    long_nxt = long_r; pos_nxt = pos_r; bnum_nxt = bnum_r; bcmp_nxt = bcmp_r;
    crc_nxt = crc_r; trl_nxt = trl_r; sum_nxt = sum_r;
    addr_nxt = addr_r; cnt_nxt = cnt_r;
    wr_en = 1'b0;
    ok = 1'b0; is_new = 1'b0; is_old = 1'b0; len = '0;
    b_nxt = '0;
    b_nxt.is_read = (op == xmr_pkg::OP_READ);

    case (op)
      xmr_pkg::OP_START: begin
        phase_nxt = xmr_pkg::PH_HEAD; retry_nxt = '0; recv_nxt = 1'b0;
        exp_nxt = 8'd1; pos_nxt = '0; addr_nxt = start_address; cnt_nxt = '0;
        b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = sbyte;
      end
      xmr_pkg::OP_READ: ;
      default: begin
        // A failed header wait: timeout, stray byte, or lone CAN.
        logic fail;
        fail = 1'b0;
        case (phase_r)
          xmr_pkg::PH_HEAD: begin
            if (op == xmr_pkg::OP_TMO) fail = 1'b1;
            else if (rx_byte == xmr_pkg::B_SOH || rx_byte == xmr_pkg::B_STX) begin
              long_nxt = (rx_byte == xmr_pkg::B_STX);
              recv_nxt = 1'b1; retry_nxt = '0; phase_nxt = xmr_pkg::PH_BLOCK;
              pos_nxt = '0; crc_nxt = '0; sum_nxt = '0; trl_nxt = '0;
            end else if (rx_byte == xmr_pkg::B_EOT) begin
              b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = xmr_pkg::B_ACK;
              phase_nxt = xmr_pkg::PH_DONE;
            end else if (rx_byte == xmr_pkg::B_CAN) phase_nxt = xmr_pkg::PH_CAN;
            else fail = 1'b1;
          end
          xmr_pkg::PH_CAN: begin
            if (op == xmr_pkg::OP_BYTE && rx_byte == xmr_pkg::B_CAN) begin
              b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = xmr_pkg::B_ACK;
              phase_nxt = xmr_pkg::PH_CANCEL;
            end else fail = 1'b1;
          end
          xmr_pkg::PH_BLOCK: begin
            if (op == xmr_pkg::OP_TMO) begin
              b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = xmr_pkg::B_NAK;
              phase_nxt = xmr_pkg::PH_HEAD; retry_nxt = '0;
            end else begin
              if (pos_r == 11'd0) bnum_nxt = rx_byte;
              else if (pos_r == 11'd1) bcmp_nxt = rx_byte;
              else if (pos_r < size + 11'd2) begin
                wr_en = (k < 11'(MAX_BLOCK));
                crc_nxt = xmr_pkg::crc_update(crc_r, rx_byte);
                sum_nxt = sum_r + rx_byte;
              end else trl_nxt = trl_new;
              pos_nxt = pos_r + 11'd1;
              if (pos_nxt >= total) begin
                // Block complete: check and answer.
                ok = (bnum_r == ~bcmp_r);
                is_new = (bnum_r == exp_r);
                is_old = (bnum_r == exp_r - 8'd1);
                if (use_crc) ok = ok && (trl_nxt == crc_nxt);
                else ok = ok && (trl_nxt[7:0] == sum_nxt);
                ok = ok && (is_new || is_old);
                phase_nxt = xmr_pkg::PH_HEAD; retry_nxt = '0;
                b_nxt.tx_valid = 1'b1;
                if (!ok) b_nxt.tx_byte = xmr_pkg::B_NAK;
                else begin
                  b_nxt.tx_byte = xmr_pkg::B_ACK;
                  if (is_new) begin
                    if (cnt_r < bytes_to_receive)
                      len = (remain > {21'd0, size}) ? size : remain[10:0];
                    if (len != 11'd0) begin
                      b_nxt.commit_valid = 1'b1;
                      b_nxt.commit_address = addr_r;
                      b_nxt.commit_length = len;
                      addr_nxt = addr_r + {21'd0, len};
                      cnt_nxt = cnt_r + {21'd0, len};
                    end
                    exp_nxt = exp_r + 8'd1;
                  end
                end
              end
            end
          end
          default: ;
        endcase
        if (fail) begin
          retry_nxt = rt_inc; phase_nxt = xmr_pkg::PH_HEAD;
          if (rt_inc >= retry_limit || rt_inc == 8'd0) begin
            b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = xmr_pkg::B_CAN;
            b_nxt.count = 2'd2; phase_nxt = xmr_pkg::PH_ABORT;
          end else if (!recv_r) begin
            b_nxt.tx_valid = 1'b1; b_nxt.tx_byte = sbyte;
          end
        end
      end
    endcase

    case (phase_nxt)
      xmr_pkg::PH_IDLE:   b_nxt.status = xmr_pkg::ST_IDLE;
      xmr_pkg::PH_DONE:   b_nxt.status = xmr_pkg::ST_DONE;
      xmr_pkg::PH_CANCEL: b_nxt.status = xmr_pkg::ST_CANCEL;
      xmr_pkg::PH_ABORT:  b_nxt.status = xmr_pkg::ST_ABORT;
      default:            b_nxt.status = xmr_pkg::ST_RUN;
    endcase
    b_nxt.total_received = cnt_nxt;
  end

  // Payload buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_go && wr_en) mem[k[AW-1:0]] <= rx_byte;
    if (in_go && op == xmr_pkg::OP_READ) begin
      rd_q <= mem[read_index[AW-1:0]];
      rd_zero_r <= ({1'b0, read_index} >= 11'(MAX_BLOCK));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xmr_pkg::PH_IDLE; retry_r <= '0; recv_r <= 1'b0; exp_r <= 8'd1;
      long_r <= 1'b0; pos_r <= '0; bnum_r <= '0; bcmp_r <= '0;
      crc_r <= '0; trl_r <= '0; sum_r <= '0; addr_r <= '0; cnt_r <= '0;
      bv_r <= 1'b0;
    end else begin
      bv_r <= in_go;
      if (in_go) begin
        phase_r <= phase_nxt; retry_r <= retry_nxt; recv_r <= recv_nxt;
        exp_r <= exp_nxt; long_r <= long_nxt; pos_r <= pos_nxt;
        bnum_r <= bnum_nxt; bcmp_r <= bcmp_nxt; crc_r <= crc_nxt;
        trl_r <= trl_nxt; sum_r <= sum_nxt; addr_r <= addr_nxt; cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) b_r <= b_nxt;
  end

  assign burst_valid = bv_r;
  assign burst       = b_r;
  assign read_data   = (b_r.is_read && !rd_zero_r) ? rd_q : 8'd0;

endmodule

// ===== hw/rtl/xmr_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmr_outq
// Four-entry burst queue that expands each burst into its result items.
// ----------------------------------------------------------------------------
module xmr_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xmr_pkg::burst_t  push_burst,
  input  logic [7:0]       push_rd,
  output logic             space,
  output logic             out_valid,
  output xmr_pkg::res_t    out_res,
  input  logic             out_ready
);

  xmr_pkg::burst_t q_b [4];
  logic [7:0]      q_rd [4];
  logic [1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic            pop, done;
  xmr_pkg::burst_t h;

  assign h = q_b[head_r];
  assign out_valid = (fill_r != 3'd0);
  assign done = (sub_r == h.count);
  assign pop = out_valid && out_ready && done;
  // Room is kept for the burst being pushed now and for the request taken now,
  // which reaches the queue in the next cycle.
  assign space = ((fill_r + {2'b00, push}) <= 3'd2);

  always_comb begin
    out_res = '0;
    out_res.tx_valid       = h.tx_valid;
    out_res.tx_byte        = h.tx_byte;
    out_res.commit_valid   = h.commit_valid;
    out_res.commit_address = h.commit_address;
    out_res.commit_length  = h.commit_length;
    out_res.status         = h.status;
    out_res.total_received = h.total_received;
    out_res.read_data      = q_rd[head_r];
    out_res.last           = done;
    head_nxt = head_r + {1'b0, pop};
    tail_nxt = tail_r + {1'b0, push};
    fill_nxt = fill_r + {2'b00, push} - {2'b00, pop};
    sub_nxt  = pop ? 2'd0 : ((out_valid && out_ready) ? sub_r + 2'd1 : sub_r);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_b[tail_r]  <= push_burst;
      q_rd[tail_r] <= push_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; fill_r <= '0; sub_r <= '0;
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt; fill_r <= fill_nxt; sub_r <= sub_nxt;
    end
  end

endmodule

// ===== hw/rtl/xmodem_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_receiver
// XMODEM block receiver with CRC-16 or checksum trailers and 128/1024 blocks.
// ----------------------------------------------------------------------------
// Each request carries one event: start, a line byte, a timeout, or a read of
// the payload buffer. The receiver answers every request with one to three
// result items (three only for the CAN abort burst); the final one has last
// set. A request is taken every cycle while in_tready is high: the protocol
// state and the CRC update are combinational logic, the payload buffer is a
// memory with a registered read, and the result passes the engine's burst
// register and a queue entry before it reaches the output. A four-entry queue
// sits between the engine and the output, so with the output ready requests
// flow back to back. The queue holds room for the request still inside the
// engine; when the output stalls, or an abort burst is sent as its three
// items, the queue fills and in_tready drops until that room opens again.
// The buffer is not cleared; an unwritten position reads as unspecified data.
module xmodem_receiver #(
  parameter int MAX_BLOCK = xmr_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata fields from bit 0: op[1:0], rx_byte[9:2], read_index[19:10]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata fields from bit 0: tx_valid, tx_byte, commit_valid, commit_address,
  // commit_length, status, total_received, read_data (bits 0..95)
  output logic [95:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        use_crc;
  logic [31:0] bytes_to_receive, start_address;
  logic [7:0]  retry_limit;
  logic        go, bvalid, space;
  xmr_pkg::burst_t burst;
  logic [7:0]  rd;
  xmr_pkg::res_t res;

  assign cfg_pready = 1'b1;
  assign in_tready  = space;
  assign go         = in_tvalid && in_tready;

  xmr_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .use_crc, .bytes_to_receive, .start_address, .retry_limit
  );

  xmr_engine #(.MAX_BLOCK(MAX_BLOCK)) u_engine (
    .clk, .rst_n, .in_go(go),
    .op(in_tdata[1:0]), .rx_byte(in_tdata[9:2]), .read_index(in_tdata[19:10]),
    .use_crc, .bytes_to_receive, .start_address, .retry_limit,
    .burst_valid(bvalid), .burst, .read_data(rd)
  );

  xmr_outq u_outq (
    .clk, .rst_n, .push(bvalid), .push_burst(burst), .push_rd(rd),
    .space, .out_valid(out_tvalid), .out_res(res), .out_ready(out_tready)
  );

  assign out_tdata = {res.read_data, res.total_received, res.status,
                      res.commit_length, res.commit_address, res.commit_valid,
                      res.tx_byte, res.tx_valid};
  assign out_tlast = res.last;

endmodule

// ===== hw/rtl/xmodem_receiver_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_receiver_checker
// Port-level checks of the XMODEM receiver, bound to the top level.
// ----------------------------------------------------------------------------
module xmodem_receiver_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  // tx_byte is zero whenever tx_valid is clear.
  a_txz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("tx_byte without tx_valid");

  // A non-final result is always a CAN of the abort burst.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata[8:1] == xmr_pkg::B_CAN && out_tdata[55:53] == xmr_pkg::ST_ABORT)
    else $error("non-final result that is not an abort CAN");

endmodule

bind xmodem_receiver xmodem_receiver_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast, .cfg_pready
);
